>>> rtl/core/grpg_pkg.sv
`timescale 1ns / 1ps

package grpg_pkg;

    // Cell geometry: a 5x7 font drawn at twice its size in a 12x14 cell.
    localparam int unsigned CellRows  = 14;
    localparam int unsigned CellCols  = 12;
    localparam int unsigned FontRows  = 7;
    localparam int unsigned FontCols  = 5;
    localparam int unsigned AlphaGlyphs = 26;
    localparam int unsigned DigitGlyphs = 10;

    localparam int unsigned PixelW = 16;
    localparam int unsigned CodeW  = 8;
    localparam int unsigned RowW   = 4;
    localparam int unsigned ColW   = 4;

    // First and last ASCII codes of the two glyph ranges.
    localparam logic [CodeW-1:0] CodeUpperA = 8'd65;
    localparam logic [CodeW-1:0] CodeUpperZ = 8'd90;
    localparam logic [CodeW-1:0] CodeDigit0 = 8'd48;
    localparam logic [CodeW-1:0] CodeDigit9 = 8'd57;

    localparam logic [ColW-1:0] LastCol = ColW'(CellCols - 1);

    // One font row: bit 4 is the leftmost font column.
    typedef logic [FontCols-1:0] t_glyph_row;

    localparam t_glyph_row ALPHA_FONT [AlphaGlyphs][FontRows] = '{
        '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
        '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
        '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
        '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
    };

    localparam t_glyph_row DIGIT_FONT [DigitGlyphs][FontRows] = '{
        '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
        '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
        '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
    };

endpackage

>>> rtl/core/glyph_row_pixel_generator_top.sv
`timescale 1ns / 1ps

// Character generator for an RGB565 text display: a 5x7 font ('A'-'Z',
// '0'-'9') drawn at twice its size in a 12x14 cell.
//
// Slave stream: one transfer names a character code, a pixel row of the cell
// and a foreground colour. The font row is looked up on acceptance and held
// in a row register, which frees the slave side for the next transfer.
// Master stream: twelve pixel transfers per input, columns 0 to 11 left to
// right, each carrying the foreground colour or zero and its column; tlast
// marks column 11. Rows 14 and 15 and codes without a glyph give blank rows.
//
// The font row of an input is held in the row register, and each pixel then
// passes through the output register. Throughput: one pixel per cycle while
// the receiver takes them; a new input waits for the held row. The next
// input is taken in the cycle its predecessor's last pixel moves to the output
// register, so rows follow one another without a gap.
//
// Reset empties the row and output registers. When the receiver stalls, the
// output register holds its pixel, the column counter stops, and tready on
// the slave side stays low for as long as a row is held.
module glyph_row_pixel_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: char_code[7:0], cell_row[11:8], fg_color[27:12], zero[31:28]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pixel_value[15:0], cell_column[19:16], zero[23:20]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tlast: row_last
    output logic        m_axis_tlast
);

    logic [grpg_pkg::CodeW-1:0]  w_char_code;
    logic [grpg_pkg::RowW-1:0]   w_cell_row;
    logic [grpg_pkg::PixelW-1:0] w_fg_color;
    grpg_pkg::t_glyph_row        w_glyph_row;

    logic                        r_row_valid;
    grpg_pkg::t_glyph_row        r_pattern;
    logic [grpg_pkg::PixelW-1:0] r_fg;
    logic [grpg_pkg::ColW-1:0]   r_col;

    logic                        r_out_valid;
    logic [grpg_pkg::PixelW-1:0] r_out_pixel;
    logic [grpg_pkg::ColW-1:0]   r_out_col;
    logic                        r_out_last;

    logic w_out_free;
    logic w_load;
    logic w_row_done;
    logic w_in_xfer;
    logic w_lit;

    // Unpack the slave transfer.
    assign w_char_code = s_axis_tdata[7:0];
    assign w_cell_row  = s_axis_tdata[11:8];
    assign w_fg_color  = s_axis_tdata[27:12];

    grpg_glyph_lookup u_glyph_lookup (
        .i_char_code (w_char_code),
        .i_cell_row  (w_cell_row),
        .o_glyph_row (w_glyph_row)
    );

    // Handshake: a pixel moves on whenever the output register is free.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_load        = r_row_valid && w_out_free;
    assign w_row_done    = w_load && (r_col == grpg_pkg::LastCol);
    assign s_axis_tready = !r_row_valid || w_row_done;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Each font column spans two pixel columns; the right margin is blank.
    always_comb begin
        case (r_col[3:1])
            3'd0:    w_lit = r_pattern[4];
            3'd1:    w_lit = r_pattern[3];
            3'd2:    w_lit = r_pattern[2];
            3'd3:    w_lit = r_pattern[1];
            3'd4:    w_lit = r_pattern[0];
            default: w_lit = 1'b0;
        endcase
    end

    // Row register and column counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= 1'b0;
            r_col       <= '0;
        end else if (w_in_xfer) begin
            r_row_valid <= 1'b1;
            r_col       <= '0;
        end else if (w_row_done) begin
            r_row_valid <= 1'b0;
        end else if (w_load) begin
            r_col <= r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pattern <= w_glyph_row;
            r_fg      <= w_fg_color;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pixel <= w_lit ? r_fg : '0;
            r_out_col   <= r_col;
            r_out_last  <= (r_col == grpg_pkg::LastCol);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_col, r_out_pixel};
    assign m_axis_tlast  = r_out_last;

    // The column counter never runs past the last column of the cell.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_valid |-> (r_col <= grpg_pkg::LastCol))
        else $error("column counter beyond the cell");

    // A new row is taken only when the held row is empty or finishing.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> (!r_row_valid || (w_load && r_col == grpg_pkg::LastCol)))
        else $error("input taken over a row still in progress");

    // Within a row, the next pixel follows at once with the next column.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && (r_out_col == $past(r_out_col) + 1'b1)))
        else $error("pixel sequence broken within a row");

    // After the last pixel of a row, any following pixel opens a new row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid || r_out_col == '0))
        else $error("new row does not start at column zero");

    // tlast accompanies exactly the last column.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_out_col == grpg_pkg::LastCol)))
        else $error("row end flag out of step with the column");

endmodule

>>> rtl/core/grpg_glyph_lookup.sv
`timescale 1ns / 1ps

module grpg_glyph_lookup (
    input  logic [grpg_pkg::CodeW-1:0] i_char_code,
    input  logic [grpg_pkg::RowW-1:0]  i_cell_row,
    output grpg_pkg::t_glyph_row       o_glyph_row
);

    logic [2:0] w_font_row;
    logic [4:0] w_alpha_off;
    logic [3:0] w_digit_off;

    // Each font row covers two cell rows.
    assign w_font_row  = i_cell_row[3:1];
    assign w_alpha_off = 5'(i_char_code - grpg_pkg::CodeUpperA);
    assign w_digit_off = 4'(i_char_code - grpg_pkg::CodeDigit0);

    // Rows below the cell and codes without a glyph read as blank.
    always_comb begin
        o_glyph_row = '0;
        if (i_cell_row < grpg_pkg::RowW'(grpg_pkg::CellRows)) begin
            if (i_char_code >= grpg_pkg::CodeUpperA && i_char_code <= grpg_pkg::CodeUpperZ) begin
                o_glyph_row = grpg_pkg::ALPHA_FONT[w_alpha_off][w_font_row];
            end else if (i_char_code >= grpg_pkg::CodeDigit0 &&
                         i_char_code <= grpg_pkg::CodeDigit9) begin
                o_glyph_row = grpg_pkg::DIGIT_FONT[w_digit_off][w_font_row];
            end
        end
    end

endmodule
